@@ hdl/b64d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADCHAR = 2'd1;
   localparam logic [1:0] ST_BADPAD  = 2'd2;

   // job queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one job: the words caused by one accepted character
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] last_idx;  // index of the final word of the job
      logic [1:0] status;
      logic       msg_end;
   } job_type;

endpackage
`default_nettype wire

@@ hdl/b64d_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front
// Character classification, quartet accumulation and error tracking.
// Emits one job per character that causes words.
// ----------------------------------------------------------------------------
module b64d_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_char,
   input  wire logic             is_final,
   output logic                  job_push,
   output b64d_pkg::job_type     job
);

   logic [23:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic        pad_ff, pad_in;
   logic        err_ff, err_in;

   logic        sx_ok;
   logic [5:0]  sx;
   logic        is_pad;
   logic [23:0] acc_shift;
   logic [1:0]  pos_inc;
   logic        push;

   always_comb begin
      sx_ok = 1'b1;
      sx    = 6'd0;
      if (in_char >= 8'h41 && in_char <= 8'h5A) begin
         sx = 6'(in_char - 8'h41);
      end else if (in_char >= 8'h61 && in_char <= 8'h7A) begin
         sx = 6'(in_char - 8'h61 + 8'd26);
      end else if (in_char >= 8'h30 && in_char <= 8'h39) begin
         sx = 6'(in_char - 8'h30 + 8'd52);
      end else if (in_char == b64d_pkg::PLUS_CHAR) begin
         sx = 6'd62;
      end else if (in_char == b64d_pkg::SLASH_CHAR) begin
         sx = 6'd63;
      end else begin
         sx_ok = 1'b0;
      end
   end

   assign is_pad    = (in_char == b64d_pkg::PAD_CHAR);
   assign acc_shift = {acc_ff[17:0], sx};
   assign pos_inc   = pos_ff + 2'd1;

   always_comb begin
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      pad_in       = pad_ff;
      err_in       = err_ff;
      push         = 1'b0;
      job.byte0    = 8'd0;
      job.byte1    = 8'd0;
      job.byte2    = 8'd0;
      job.last_idx = 2'd0;
      job.status   = b64d_pkg::ST_OK;
      job.msg_end  = is_final;

      if (err_ff) begin
         if (is_final) begin
            err_in = 1'b0;
            acc_in = 24'd0;
            pos_in = 2'd0;
            pad_in = 1'b0;
         end
      end else begin
         priority if (is_pad) begin
            if (pos_ff < 2'd2 || (pos_ff == 2'd2 && is_final) ||
                (pos_ff == 2'd3 && !is_final)) begin
               push       = 1'b1;
               job.status = b64d_pkg::ST_BADPAD;
            end else if (pos_ff == 2'd2) begin
               pad_in = 1'b1;
               pos_in = 2'd3;
            end else begin
               push = 1'b1;
               if (!pad_ff) begin
                  job.byte0    = acc_ff[17:10];
                  job.byte1    = acc_ff[9:2];
                  job.last_idx = 2'd1;
               end else begin
                  job.byte0 = acc_ff[11:4];
               end
            end
         end else if (!sx_ok) begin
            push       = 1'b1;
            job.status = b64d_pkg::ST_BADCHAR;
         end else if (pad_ff || (pos_inc != 2'd0 && is_final)) begin
            push       = 1'b1;
            job.status = b64d_pkg::ST_BADPAD;
         end else if (pos_inc != 2'd0) begin
            acc_in = acc_shift;
            pos_in = pos_inc;
         end else begin
            push         = 1'b1;
            job.byte0    = acc_shift[23:16];
            job.byte1    = acc_shift[15:8];
            job.byte2    = acc_shift[7:0];
            job.last_idx = 2'd2;
         end

         if (push) begin
            acc_in = 24'd0;
            pos_in = 2'd0;
            pad_in = 1'b0;
            if (job.status != b64d_pkg::ST_OK) begin
               err_in = !is_final;
            end
         end
      end
   end

   assign job_push = accept && push;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 24'd0;
         pos_ff <= 2'd0;
         pad_ff <= 1'b0;
         err_ff <= 1'b0;
      end else if (accept) begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
         pad_ff <= pad_in;
         err_ff <= err_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/b64d_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module b64d_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire b64d_pkg::job_type   push_job,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output b64d_pkg::job_type        head_job
);

   b64d_pkg::job_type mem [b64d_pkg::QUEUE_DEPTH];

   logic [b64d_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == b64d_pkg::QPTR_W'(b64d_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + b64d_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == b64d_pkg::QPTR_W'(b64d_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + b64d_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + b64d_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - b64d_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/b64d_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back
// Splits each queued job into result words and holds them in an output
// register.
// ----------------------------------------------------------------------------
module b64d_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                empty,
   input  wire b64d_pkg::job_type   head_job,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic [1:0]               rsp_status,
   output logic                     rsp_run_last,
   output logic                     rsp_msg_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] status_ff;
   logic       last_ff, last_in;
   logic       end_ff;
   logic       load;

   assign load    = !empty && (!valid_ff || rsp_ready);
   assign last_in = (idx_ff == head_job.last_idx);
   assign pop     = load && last_in;

   always_comb begin
      unique case (idx_ff)
         2'd0:    byte_in = head_job.byte0;
         2'd1:    byte_in = head_job.byte1;
         default: byte_in = head_job.byte2;
      endcase
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_in ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         status_ff <= head_job.status;
         last_ff   <= last_in;
         end_ff    <= last_in && head_job.msg_end;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status   = status_ff;
   assign rsp_run_last = last_ff;
   assign rsp_msg_end  = end_ff;

endmodule
`default_nettype wire

@@ hdl/base64_stream_decoder_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character in, up to three bytes out.
//
//   channel   dir  handshake              payload
//   req_      in   req_valid/req_ready    req_in_char[7:0], req_is_final
//   rsp_      out  rsp_valid/rsp_ready    rsp_out_byte[7:0], rsp_status[1:0],
//                                         rsp_run_last, rsp_msg_end
//
// One character per cycle is taken while the job queue has room; the front
// updates the quartet state in the accept cycle.
// The back drains one word per cycle while rsp_ready is high, via the queue
// and the output register. Four characters give at most three words.
// Synchronous reset clears all control state; no clearing pass.
// rsp_ready low fills the queue, after which req_ready drops.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_char,
   input  wire logic       req_is_final,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_status,
   output logic            rsp_run_last,
   output logic            rsp_msg_end
);

   logic              accept;
   logic              job_push;
   b64d_pkg::job_type job;
   b64d_pkg::job_type head_job;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   b64d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_char  (req_in_char),
      .is_final (req_is_final),
      .job_push (job_push),
      .job      (job)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_job (head_job)
   );

   b64d_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (q_empty),
      .head_job     (head_job),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last),
      .rsp_msg_end  (rsp_msg_end)
   );

endmodule
`default_nettype wire
